/* rtl/infix_to_postfix_converter_macros.svh */
// Assertion macros for the infix-to-postfix converter.
// Both macros sample on clk_i and are disabled while rst_ni is low.
`ifndef INFIX_TO_POSTFIX_CONVERTER_MACROS_SVH
`define INFIX_TO_POSTFIX_CONVERTER_MACROS_SVH
`ifndef SYNTH
`define ITP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define ITP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ITP_ASSERT_IMP(lbl, ante, cons, msg)
`define ITP_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

/* rtl/itp_pkg.sv */
package itp_pkg;

  localparam int unsigned STACK_DEPTH_DEF = 32;

  localparam logic [3:0] K_NUM    = 4'd0;
  localparam logic [3:0] K_NAME   = 4'd1;
  localparam logic [3:0] K_FUNC   = 4'd2;
  localparam logic [3:0] K_PLUS   = 4'd3;
  localparam logic [3:0] K_MINUS  = 4'd4;
  localparam logic [3:0] K_MUL    = 4'd5;
  localparam logic [3:0] K_DIV    = 4'd6;
  localparam logic [3:0] K_POW    = 4'd7;
  localparam logic [3:0] K_LEFT   = 4'd8;
  localparam logic [3:0] K_RIGHT  = 4'd9;
  localparam logic [3:0] K_END    = 4'd10;
  localparam logic [3:0] K_UMINUS = 4'd11;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_SYNTAX   = 2'd1;
  localparam logic [1:0] ST_MISMATCH = 2'd2;
  localparam logic [1:0] ST_OVERFLOW = 2'd3;

  typedef struct packed {
    logic [3:0]  kind;
    logic [63:0] value_bits;
    logic [7:0]  symbol_id;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  out_kind;
    logic [63:0] out_value_bits;
    logic [7:0]  out_symbol_id;
    logic [1:0]  status;
    logic        last;
  } out_item_t;

  // One operator stack entry: kind and symbol.
  typedef struct packed {
    logic [3:0] kind;
    logic [7:0] sym;
  } entry_t;

  // Port strobes from the sequencer to the stack memory.
  typedef struct packed {
    logic rd;
    logic wr;
  } stk_ctl_t;

  // Mask of kinds allowed to follow the previous kind.
  function automatic logic [15:0] next_ok(input logic [3:0] prev);
    logic [15:0] m;
    case (prev)
      K_NUM, K_NAME, K_RIGHT:                   m = 16'h06F8;
      K_FUNC:                                   m = 16'h0100;
      K_PLUS, K_MINUS, K_MUL, K_DIV, K_POW:     m = 16'h0107;
      K_LEFT, K_END:                            m = 16'h0117;
      K_UMINUS:                                 m = 16'h0107;
      default:                                  m = 16'h0000;
    endcase
    return m;
  endfunction

  function automatic logic is_op(input logic [3:0] k);
    return ((k >= K_PLUS) && (k <= K_POW)) || (k == K_UMINUS);
  endfunction

  function automatic logic [1:0] prec(input logic [3:0] k);
    logic [1:0] p;
    if ((k == K_MUL) || (k == K_DIV)) begin
      p = 2'd2;
    end else if (k == K_POW) begin
      p = 2'd3;
    end else begin
      p = 2'd1;
    end
    return p;
  endfunction

  // True when the operator on top must leave before the incoming one is pushed.
  function automatic logic pop_ok(input logic [3:0] k, input logic [3:0] top);
    logic p;
    if (k == K_POW) begin
      p = prec(k) < prec(top);
    end else begin
      p = prec(k) <= prec(top);
    end
    return is_op(top) && p;
  endfunction

  function automatic out_item_t mk_entry(input entry_t e);
    out_item_t r;
    r.out_kind       = e.kind;
    r.out_value_bits = '0;
    r.out_symbol_id  = e.sym;
    r.status         = ST_OK;
    r.last           = 1'b0;
    return r;
  endfunction

  function automatic out_item_t mk_final(input logic [1:0] st);
    out_item_t r;
    r.out_kind       = K_END;
    r.out_value_bits = '0;
    r.out_symbol_id  = '0;
    r.status         = st;
    r.last           = 1'b1;
    return r;
  endfunction

endpackage

/* rtl/itp_stack.sv */
module itp_stack
  import itp_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF,
  localparam int unsigned AW = $clog2(STACK_DEPTH)
) (
  input  logic          clk_i,
  input  stk_ctl_t      ctl_i,
  input  logic [AW-1:0] rd_addr_i,
  input  logic [AW-1:0] wr_addr_i,
  input  entry_t        wr_data_i,
  output entry_t        rd_data_o
);

  entry_t mem_q [STACK_DEPTH];
  entry_t rd_data_q;

  // Single write port and one registered read port. Read data holds when idle.
  always_ff @(posedge clk_i) begin
    if (ctl_i.wr) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (ctl_i.rd) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

/* rtl/itp_ctrl.sv */
module itp_ctrl
  import itp_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF,
  localparam int unsigned AW = $clog2(STACK_DEPTH),
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  in_item_t      in_item_i,
  input  logic          out_free_i,
  output logic          emit_o,
  output out_item_t     res_o,
  output stk_ctl_t      stk_ctl_o,
  output logic [AW-1:0] rd_addr_o,
  output logic [AW-1:0] wr_addr_o,
  output entry_t        wr_data_o,
  input  entry_t        rd_data_i
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DISP = 3'd1;
  localparam logic [2:0] S_READ = 3'd2;
  localparam logic [2:0] S_EVAL = 3'd3;
  localparam logic [2:0] S_PUSH = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  localparam logic [1:0] M_OP    = 2'd0;
  localparam logic [1:0] M_RIGHT = 2'd1;
  localparam logic [1:0] M_FUNC  = 2'd2;
  localparam logic [1:0] M_END   = 2'd3;

  logic [2:0]    state_q, state_d;
  logic [1:0]    mode_q, mode_d;
  logic [3:0]    k_q, k_d;
  logic [3:0]    prev_q, prev_d;
  logic          skip_q, skip_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] paren_q, paren_d;
  logic [CW-1:0] cnt_m1;
  in_item_t      item_q;
  logic [15:0]   ok_mask;
  logic          syn_ok;
  logic          err_go;
  logic          err_skip;
  logic [1:0]    err_st;

  assign in_ready_o = (state_q == S_IDLE);
  assign cnt_m1     = count_q - CW'(1);
  assign rd_addr_o  = cnt_m1[AW-1:0];
  assign wr_addr_o  = count_q[AW-1:0];
  assign ok_mask    = next_ok(prev_q);
  assign syn_ok     = ok_mask[k_q];

  always_comb begin
    wr_data_o.kind = k_q;
    wr_data_o.sym  = (k_q == K_FUNC) ? item_q.symbol_id : 8'd0;
  end

  always_comb begin
    state_d   = state_q;
    mode_d    = mode_q;
    k_d       = k_q;
    prev_d    = prev_q;
    skip_d    = skip_q;
    count_d   = count_q;
    paren_d   = paren_q;
    emit_o    = 1'b0;
    res_o     = '0;
    stk_ctl_o = '0;
    err_go    = 1'b0;
    err_skip  = 1'b1;
    err_st    = ST_OK;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          k_d     = in_item_i.kind;
          state_d = S_DISP;
        end
      end

      S_DISP: begin
        if (skip_q) begin
          if (k_q == K_END) begin
            skip_d  = 1'b0;
            count_d = '0;
            paren_d = '0;
            prev_d  = K_END;
          end
          state_d = S_IDLE;
        end else if (out_free_i) begin
          if (k_q == K_END) begin
            if (paren_q != '0) begin
              err_go   = 1'b1;
              err_st   = ST_MISMATCH;
              err_skip = 1'b0;
            end else if (count_q != '0) begin
              mode_d  = M_END;
              state_d = S_READ;
            end else begin
              state_d = S_FIN;
            end
          end else if (k_q == K_RIGHT) begin
            if (paren_q == '0) begin
              err_go = 1'b1;
              err_st = ST_MISMATCH;
            end else if (!syn_ok) begin
              err_go = 1'b1;
              err_st = ST_SYNTAX;
            end else begin
              prev_d  = K_RIGHT;
              mode_d  = M_RIGHT;
              state_d = S_READ;
            end
          end else if (!syn_ok) begin
            err_go = 1'b1;
            err_st = ST_SYNTAX;
          end else begin
            case (k_q) inside
              K_NUM, K_NAME: begin
                emit_o               = 1'b1;
                res_o.out_kind       = k_q;
                res_o.out_value_bits = (k_q == K_NUM) ? item_q.value_bits : 64'd0;
                res_o.out_symbol_id  = (k_q == K_NAME) ? item_q.symbol_id : 8'd0;
                res_o.status         = ST_OK;
                res_o.last           = 1'b0;
                prev_d               = k_q;
                state_d              = S_IDLE;
              end
              K_FUNC, K_LEFT: begin
                prev_d  = k_q;
                state_d = S_PUSH;
              end
              default: begin
                // Binary operators; a leading minus turns unary.
                if ((k_q == K_MINUS) && ((prev_q == K_END) || (prev_q == K_LEFT))) begin
                  k_d    = K_UMINUS;
                  prev_d = K_UMINUS;
                end else begin
                  prev_d = k_q;
                end
                mode_d  = M_OP;
                state_d = (count_q == '0) ? S_PUSH : S_READ;
              end
            endcase
          end
        end
      end

      S_READ: begin
        stk_ctl_o.rd = 1'b1;
        state_d      = S_EVAL;
      end

      S_EVAL: begin
        if (out_free_i) begin
          unique case (mode_q)
            M_OP: begin
              if (pop_ok(k_q, rd_data_i.kind)) begin
                emit_o  = 1'b1;
                res_o   = mk_entry(rd_data_i);
                count_d = cnt_m1;
                state_d = (cnt_m1 == '0) ? S_PUSH : S_READ;
              end else begin
                state_d = S_PUSH;
              end
            end
            M_RIGHT: begin
              if (is_op(rd_data_i.kind) || (rd_data_i.kind == K_FUNC)) begin
                emit_o  = 1'b1;
                res_o   = mk_entry(rd_data_i);
                count_d = cnt_m1;
                state_d = S_READ;
              end else begin
                // Matching left parenthesis: drop it, then look for a function.
                count_d = cnt_m1;
                paren_d = paren_q - CW'(1);
                if (cnt_m1 != '0) begin
                  mode_d  = M_FUNC;
                  state_d = S_READ;
                end else begin
                  state_d = S_IDLE;
                end
              end
            end
            M_FUNC: begin
              if (rd_data_i.kind == K_FUNC) begin
                emit_o  = 1'b1;
                res_o   = mk_entry(rd_data_i);
                count_d = cnt_m1;
              end
              state_d = S_IDLE;
            end
            M_END: begin
              emit_o  = 1'b1;
              res_o   = mk_entry(rd_data_i);
              count_d = cnt_m1;
              state_d = (cnt_m1 == '0) ? S_FIN : S_READ;
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end

      S_PUSH: begin
        if (out_free_i) begin
          if (count_q >= CW'(STACK_DEPTH)) begin
            err_go = 1'b1;
            err_st = ST_OVERFLOW;
          end else begin
            stk_ctl_o.wr = 1'b1;
            count_d      = count_q + CW'(1);
            if (k_q == K_LEFT) begin
              paren_d = paren_q + CW'(1);
            end
            state_d = S_IDLE;
          end
        end
      end

      S_FIN: begin
        if (out_free_i) begin
          emit_o  = 1'b1;
          res_o   = mk_final(ST_OK);
          count_d = '0;
          paren_d = '0;
          prev_d  = K_END;
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    // An error ends the expression with one result and clears the stack.
    if (err_go) begin
      emit_o  = 1'b1;
      res_o   = mk_final(err_st);
      count_d = '0;
      paren_d = '0;
      prev_d  = K_END;
      skip_d  = err_skip;
      state_d = S_IDLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      mode_q  <= M_OP;
      k_q     <= K_END;
      prev_q  <= K_END;
      skip_q  <= 1'b0;
      count_q <= '0;
      paren_q <= '0;
    end else begin
      state_q <= state_d;
      mode_q  <= mode_d;
      k_q     <= k_d;
      prev_q  <= prev_d;
      skip_q  <= skip_d;
      count_q <= count_d;
      paren_q <= paren_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= in_item_i;
    end
  end

endmodule

/* rtl/infix_to_postfix_converter.sv */
// Channel  Direction  Handshake             Payload
// -------  ---------  --------------------  ----------------------------------------
// in       input      in_valid_i/in_ready_o  in_item_i: kind, value_bits, symbol_id
// out      output     out_valid_o/out_ready_i out_item_o: kind, value, symbol, status, last
//
// An item is accepted, then dispatched; for every operator stack entry it examines
// the sequencer does a memory read and then an evaluate, followed by a push where
// the item is stacked and by the closing end result where the expression ends.
// The registered read of the stack memory is why each entry needs its own read step.
// Reset clears the sequencer, the stack count and the skip flag; the stack memory
// itself is never cleared, since only entries below the count are read.
// A stalled output holds the sequencer at its next result; the output register
// still lets one result wait while the sequencer reads the next stack entry.
`include "infix_to_postfix_converter_macros.svh"

module infix_to_postfix_converter
  import itp_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  localparam int unsigned AW = $clog2(STACK_DEPTH);

  logic          out_valid_q;
  out_item_t     out_item_q;
  logic          out_free;
  logic          emit;
  out_item_t     res;
  stk_ctl_t      stk_ctl;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  entry_t        wr_data;
  entry_t        rd_data;
  logic          in_acc;
  logic          out_err;
  logic          out_end;

  // The output register is free when empty or when its item leaves this cycle.
  assign out_free = !out_valid_q || out_ready_i;

  // The sequencer walks the operator stack one entry per read and evaluate pair,
  // using the precedence compare for the pop decisions of an incoming operator.
  itp_ctrl #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .out_free_i (out_free),
    .emit_o     (emit),
    .res_o      (res),
    .stk_ctl_o  (stk_ctl),
    .rd_addr_o  (rd_addr),
    .wr_addr_o  (wr_addr),
    .wr_data_o  (wr_data),
    .rd_data_i  (rd_data)
  );

  // Operator stack storage.
  itp_stack #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_stack (
    .clk_i     (clk_i),
    .ctl_i     (stk_ctl),
    .rd_addr_i (rd_addr),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_data_o (rd_data)
  );

  // Output register: loaded when the sequencer emits, emptied when taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_item_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  assign in_acc  = in_valid_i && in_ready_o;
  assign out_err = out_valid_o && (out_item_o.status != ST_OK);
  assign out_end = out_item_o.last && (out_item_o.out_kind == K_END);

  // The sequencer must never overwrite a result that has not been taken.
  `ITP_ASSERT_IMP(a_emit_room, emit, out_free, "result emitted into a full output register")
  // The block works on one item at a time.
  `ITP_ASSERT_NXT(a_busy_after_accept, in_acc, !in_ready_o, "ready right after accept")
  // Every error result closes the expression as an end item.
  `ITP_ASSERT_IMP(a_err_is_final, out_err, out_end, "error result not final")

endmodule
